// ===== design/elv_pkg.sv =====
`default_nettype none
package elv_pkg;

	localparam int FLOOR_W = 6;
	localparam int CAR_W   = 5;
	localparam int CFG_W   = 6;

	localparam logic [CFG_W-1:0] TOTAL_FLOORS_RST = 6'd10;

	typedef enum logic [0:0] {
		ACT_REQUEST = 1'b0,
		ACT_RUN     = 1'b1
	} action_t;

	typedef enum logic [1:0] {
		KIND_STATUS = 2'd0,
		KIND_STEP   = 2'd1,
		KIND_IDLE   = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		ST_UP      = 2'd0,
		ST_DOWN    = 2'd1,
		ST_HERE    = 2'd2,
		ST_INVALID = 2'd3
	} status_t;

	// controller -> datapath
	typedef struct packed {
		logic req;   // floor request: status result, mark pending
		logic start; // run begins: trim pending sets
		logic idle;  // run with nothing pending
		logic step;  // move car one floor
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic             slot_free; // output register can take a result
		logic             run_empty; // nothing to serve on a run
		logic             step_last; // current step ends the run
		logic             up_busy;   // current step goes up
		logic [CAR_W-1:0] car;
	} stat_t;

endpackage
`default_nettype wire

// ===== design/elv_ctrl.sv =====
`default_nettype none
module elv_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          s_tvalid,
	input  wire logic          s_tuser,
	output logic               s_tready,
	input  elv_pkg::stat_t     stat,
	output elv_pkg::cmd_t      cmd
);
	import elv_pkg::*;

	typedef enum logic [0:0] {
		S_IDLE,
		S_RUN
	} state_t;

	state_t state_q;
	logic   accept;

	assign s_tready = (state_q == S_IDLE) && stat.slot_free;
	assign accept   = s_tvalid && s_tready;

	always_comb begin
		cmd = '0;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					if (s_tuser == ACT_REQUEST) begin
						cmd.req = 1'b1;
					end else if (stat.run_empty) begin
						cmd.idle = 1'b1;
					end else begin
						cmd.start = 1'b1;
					end
				end
			end
			S_RUN: begin
				cmd.step = stat.slot_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (cmd.start) begin
						state_q <= S_RUN;
					end
				end
				S_RUN: begin
					if (cmd.step && stat.step_last) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule
`default_nettype wire

// ===== design/elv_dp.sv =====
`default_nettype none
module elv_dp #(
	parameter int NUM_FLOORS = 32
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         cfg_we,
	input  wire logic [elv_pkg::CFG_W-1:0]    cfg_wdata,
	input  wire logic [elv_pkg::FLOOR_W-1:0]  floor,
	input  elv_pkg::cmd_t                     cmd,
	output elv_pkg::stat_t                    stat,
	output logic                              m_tvalid,
	input  wire logic                         m_tready,
	output logic [15:0]                       m_tdata,
	output logic [1:0]                        m_tuser,
	output logic                              m_tlast
);
	import elv_pkg::*;

	localparam logic [CFG_W-1:0]      NUM_F = CFG_W'(NUM_FLOORS);
	localparam logic [NUM_FLOORS-1:0] ONE   = NUM_FLOORS'(1);

	logic [CFG_W-1:0]      total_floors_q;
	logic [CAR_W-1:0]      car_q;
	logic [NUM_FLOORS-1:0] up_q;
	logic [NUM_FLOORS-1:0] down_q;

	logic            out_valid_q;
	kind_t           kind_q;
	status_t         status_q;
	logic [CAR_W-1:0] car_out_q;
	logic            going_up_q;
	logic            hit_q;
	logic            last_q;

	logic [CFG_W-1:0]      limit;
	status_t               req_status;
	logic [NUM_FLOORS-1:0] floor_bit;
	logic [NUM_FLOORS-1:0] car_bit;
	logic [NUM_FLOORS-1:0] below_mask;
	logic [NUM_FLOORS-1:0] above_mask;
	logic [NUM_FLOORS-1:0] up_trim;
	logic [NUM_FLOORS-1:0] down_trim;
	logic                  up_busy;
	logic [CAR_W-1:0]      car_nx;
	logic [NUM_FLOORS-1:0] step_bit;
	logic                  step_hit;
	logic [NUM_FLOORS-1:0] up_nx;
	logic [NUM_FLOORS-1:0] down_nx;

	assign limit = (total_floors_q > NUM_F) ? NUM_F : total_floors_q;

	always_comb begin
		if (floor >= limit) begin
			req_status = ST_INVALID;
		end else if (floor > {1'b0, car_q}) begin
			req_status = ST_UP;
		end else if (floor < {1'b0, car_q}) begin
			req_status = ST_DOWN;
		end else begin
			req_status = ST_HERE;
		end
	end

	assign floor_bit  = ONE << floor;
	assign car_bit    = ONE << car_q;
	assign below_mask = car_bit - ONE;
	assign above_mask = ~(below_mask | car_bit);
	assign up_trim    = up_q & above_mask;
	assign down_trim  = down_q & below_mask;

	assign up_busy  = |up_q;
	assign car_nx   = up_busy ? car_q + CAR_W'(1) : car_q - CAR_W'(1);
	assign step_bit = ONE << car_nx;
	assign step_hit = up_busy ? |(up_q & step_bit) : |(down_q & step_bit);
	assign up_nx    = up_busy ? (up_q & ~step_bit) : up_q;
	assign down_nx  = up_busy ? down_q : (down_q & ~step_bit);

	assign stat.slot_free = !out_valid_q || m_tready;
	assign stat.run_empty = (up_trim == '0) && (down_trim == '0);
	assign stat.step_last = (up_nx == '0) && (down_nx == '0);
	assign stat.up_busy   = up_busy;
	assign stat.car       = car_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_floors_q <= TOTAL_FLOORS_RST;
			car_q          <= '0;
			up_q           <= '0;
			down_q         <= '0;
			out_valid_q    <= 1'b0;
		end else begin
			if (cfg_we) begin
				total_floors_q <= cfg_wdata;
			end
			if (cmd.req || cmd.idle || cmd.step) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			if (cmd.req) begin
				if (req_status == ST_UP) begin
					up_q <= up_q | floor_bit;
				end else if (req_status == ST_DOWN) begin
					down_q <= down_q | floor_bit;
				end
			end
			if (cmd.idle) begin
				up_q   <= '0;
				down_q <= '0;
			end
			if (cmd.start) begin
				up_q   <= up_trim;
				down_q <= down_trim;
			end
			if (cmd.step) begin
				car_q  <= car_nx;
				up_q   <= up_nx;
				down_q <= down_nx;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.req) begin
			kind_q     <= KIND_STATUS;
			status_q   <= req_status;
			car_out_q  <= car_q;
			going_up_q <= 1'b0;
			hit_q      <= 1'b0;
			last_q     <= 1'b1;
		end else if (cmd.idle) begin
			kind_q     <= KIND_IDLE;
			status_q   <= ST_UP;
			car_out_q  <= car_q;
			going_up_q <= 1'b0;
			hit_q      <= 1'b0;
			last_q     <= 1'b1;
		end else if (cmd.step) begin
			kind_q     <= KIND_STEP;
			status_q   <= ST_UP;
			car_out_q  <= car_nx;
			going_up_q <= up_busy;
			hit_q      <= step_hit;
			last_q     <= stat.step_last;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = kind_q;
	assign m_tlast  = last_q;
	assign m_tdata  = {7'd0, hit_q, going_up_q, car_out_q, status_q};

endmodule
`default_nettype wire

// ===== design/elevator_look_scheduler.sv =====
// Channel  | Signals                        | Contents
// s_*      | s_tvalid s_tready s_tdata s_tuser | request in: floor, action
// m_*      | m_tvalid m_tready m_tdata m_tuser m_tlast | result out
// cfg_*    | cfg_we cfg_wdata               | total_floors write
//
// A floor request gives one status result.
// A run first trims the pending sets, then steps the car floor by floor
// (up to 2*NUM_FLOORS-3 steps); the car moves one floor per step register update.
// A run with nothing pending gives its idle result.
// A stalled m_tready holds the output register and with it the run and s_tready.
// Reset puts the car on the ground floor, clears both pending sets, floors to 10.
`default_nettype none
module elevator_look_scheduler #(
	parameter int NUM_FLOORS = 32
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [5:0]  cfg_wdata,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,  // [5:0] floor
	input  wire logic        s_tuser,  // [0] action
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [15:0]      m_tdata,  // [1:0] status, [6:2] car_floor, [7] going_up,
	                                   // [8] target_reached
	output logic [1:0]       m_tuser,  // [1:0] kind
	output logic             m_tlast
);
	import elv_pkg::*;

	cmd_t  cmd;
	stat_t stat;

	elv_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tuser  (s_tuser),
		.s_tready (s_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	elv_dp #(
		.NUM_FLOORS (NUM_FLOORS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.floor     (s_tdata[FLOOR_W-1:0]),
		.cmd       (cmd),
		.stat      (stat),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast)
	);

	a_cmd_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.req, cmd.start, cmd.idle, cmd.step}))
		else $error("more than one datapath command");

	a_no_accept_in_run: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.step |-> !s_tready)
		else $error("request taken during a run");

	a_result_slot: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.req || cmd.idle || cmd.step) |-> stat.slot_free)
		else $error("result written over a pending result");

	a_step_up: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.step && stat.up_busy) |=> (stat.car == $past(stat.car) + 5'd1))
		else $error("up step did not advance the car");

endmodule
`default_nettype wire
